// ===== rtl/priority_sjf_aging_scheduler_assert.svh =====
// Assertion macros shared by the scheduler's checker.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef PRIORITY_SJF_AGING_SCHEDULER_ASSERT_SVH
`define PRIORITY_SJF_AGING_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PSAS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed: same-cycle implication");

// next-cycle implication
`define PSAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed: next-cycle implication");

`endif

// ===== rtl/psas_pkg.sv =====
// Shared types and constants for the priority/SJF aging scheduler.
// No dependencies.
`default_nettype none

package psas_pkg;

   localparam int MaxTasks = 16;
   localparam int SlotW    = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
   localparam int CntW     = $clog2(MaxTasks + 1);

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   typedef logic [7:0]  ident_type;
   typedef logic [15:0] time_type;
   typedef logic [3:0]  prio_type;
   typedef logic [3:0]  slot_field_type;
   typedef logic [SlotW-1:0] slot_idx_type;
   typedef logic [CntW-1:0]  count_type;
   typedef logic [CsrIdxW-1:0] csr_idx_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam csr_idx_type CSR_AGE_LIMIT   = 2'd0;
   localparam csr_idx_type CSR_AGING_BOOST = 2'd1;

   localparam time_type RST_AGE_LIMIT   = 16'd15;
   localparam prio_type RST_AGING_BOOST = 4'd1;
   localparam time_type TIME_MAX        = 16'hFFFF;

   typedef struct packed {
      ident_type ident;
      time_type  arrival;
      time_type  remaining;
      prio_type  prio;
      time_type  wait_mark;
   } slot_rec_type;

   typedef struct packed {
      time_type       tick_time;
      logic           idle;
      slot_field_type running_slot;
      ident_type      running_id;
      logic           context_switch;
      logic           first_run;
      logic           finished;
      time_type       finish_tick;
      logic           all_done;
      time_type       switch_count;
   } rsp_payload_type;

   function automatic time_type sat_inc(time_type v);
      return (v == TIME_MAX) ? v : time_type'(v + 16'd1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/psas_if.sv =====
// Valid/ready channel interfaces: request, result and register write.
// Depends on psas_pkg.
`default_nettype none

interface psas_req_if import psas_pkg::*; ();
   logic           valid;
   logic           ready;
   logic           opcode;
   slot_field_type slot;
   ident_type      task_id;
   time_type       arrive_at;
   time_type       burst_length;
   prio_type       initial_priority;

   modport source (output valid, opcode, slot, task_id, arrive_at, burst_length,
                   initial_priority, input ready);
   modport sink   (input valid, opcode, slot, task_id, arrive_at, burst_length,
                   initial_priority, output ready);
endinterface

interface psas_rsp_if import psas_pkg::*; ();
   logic           valid;
   logic           ready;
   time_type       tick_time;
   logic           idle;
   slot_field_type running_slot;
   ident_type      running_id;
   logic           context_switch;
   logic           first_run;
   logic           finished;
   time_type       finish_tick;
   logic           all_done;
   time_type       switch_count;

   modport source (output valid, tick_time, idle, running_slot, running_id, context_switch,
                   first_run, finished, finish_tick, all_done, switch_count,
                   input ready);
   modport sink   (input valid, tick_time, idle, running_slot, running_id, context_switch,
                   first_run, finished, finish_tick, all_done, switch_count,
                   output ready);
endinterface

interface psas_csr_if import psas_pkg::*; ();
   logic                valid;
   logic                ready;
   csr_idx_type         index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/priority_sjf_aging_scheduler.sv =====
// Preemptive priority / shortest-remaining-time scheduler with aging.
// Depends on psas_pkg and the channel interfaces in psas_if.sv.
//
// Channels: req_ch takes load items (write one task slot) and tick items
// (advance time one unit); rsp_ch returns one result per tick, none per
// load; csr_ch writes the aging wait limit (index 0) and the aging boost
// (index 1) and is always ready.
// A load leaves the block in idle, so req_ch stays ready.
// A tick sweeps the slot store through one read port and one shared
// admit/age/compare datapath, one slot per cycle: an accept step, one scan
// step per slot, then a run step. The result becomes valid in the same cycle
// that req_ch is ready again, so a new item is taken only once the previous
// tick has run.
// The result sits in an output register, so a new item may be taken while
// it waits. If the sink still stalls when the next tick reaches its run
// cycle, that tick holds there until the output register frees.
// Reset (synchronous, active high) empties all slots, zeroes time, the
// switch count and the previous-task history, and restores the aging
// registers to 15 and 1. No clearing pass is needed.
`default_nettype none

module priority_sjf_aging_scheduler import psas_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   psas_req_if.sink   req_ch,
   psas_rsp_if.source rsp_ch,
   psas_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0] state_ff, state_in;
   slot_idx_type idx_ff, idx_in;

   // slot store: one write port, one registered read port
   slot_rec_type slot_mem [MaxTasks];
   slot_rec_type rd_rec_ff;
   logic         wr_en;
   slot_idx_type wr_addr;
   slot_rec_type wr_rec;
   slot_idx_type rd_addr;

   logic [MaxTasks-1:0] valid_ff, valid_in;
   logic [MaxTasks-1:0] queued_ff, queued_in;
   logic [MaxTasks-1:0] started_ff, started_in;

   logic         best_found_ff, best_found_in;
   slot_idx_type best_idx_ff, best_idx_in;
   slot_rec_type best_rec_ff, best_rec_in;
   count_type    pend_ff, pend_in;

   time_type  now_ff, now_in;
   ident_type prev_id_ff, prev_id_in;
   logic      prev_busy_ff, prev_busy_in;
   time_type  sw_total_ff, sw_total_in;
   time_type  thr_ff;
   prio_type  boost_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic req_xfer, out_free, load_ok;

   // per-slot scan datapath
   logic     s_valid, s_queued, s_adm, s_q1, s_age, s_cand, s_better, s_last;
   time_type s_mark1, s_waited;
   prio_type s_prio2;

   // run datapath
   time_type now_next, new_rem;
   logic     fin, sw;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign load_ok      = 32'(req_ch.slot) < MaxTasks;
   assign s_last       = (32'(idx_ff) == MaxTasks - 1);

   always_comb begin
      s_valid  = valid_ff[idx_ff];
      s_queued = queued_ff[idx_ff];
      s_adm    = s_valid && !s_queued && (rd_rec_ff.remaining != '0) &&
                 (rd_rec_ff.arrival <= now_ff);
      s_q1     = s_queued || s_adm;
      s_mark1  = s_adm ? now_ff : rd_rec_ff.wait_mark;
      s_waited = (now_ff >= s_mark1) ? time_type'(now_ff - s_mark1) : '0;
      s_age    = s_valid && s_q1 && (rd_rec_ff.prio > 4'd1) && (s_waited >= thr_ff);
      s_prio2  = rd_rec_ff.prio;
      if (s_age) begin
         s_prio2 = ({1'b0, rd_rec_ff.prio} > ({1'b0, boost_ff} + 5'd1)) ?
                   prio_type'(rd_rec_ff.prio - boost_ff) : 4'd1;
      end
      s_cand   = s_valid && s_q1 && (rd_rec_ff.remaining != '0);
      s_better = s_cand && (!best_found_ff || (s_prio2 < best_rec_ff.prio) ||
                 ((s_prio2 == best_rec_ff.prio) &&
                  (rd_rec_ff.remaining < best_rec_ff.remaining)));
   end

   assign now_next = sat_inc(now_ff);
   assign new_rem  = time_type'(best_rec_ff.remaining - 16'd1);
   assign fin      = (new_rem == '0);
   assign sw       = prev_busy_ff && (prev_id_ff != best_rec_ff.ident);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      queued_in     = queued_ff;
      started_in    = started_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_rec_in   = best_rec_ff;
      pend_in       = pend_ff;
      now_in        = now_ff;
      prev_id_in    = prev_id_ff;
      prev_busy_in  = prev_busy_ff;
      sw_total_in   = sw_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_rec        = rd_rec_ff;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_ch.opcode == OP_LOAD) begin
                  if (load_ok) begin
                     wr_en            = 1'b1;
                     wr_addr          = slot_idx_type'(req_ch.slot);
                     wr_rec.ident     = req_ch.task_id;
                     wr_rec.arrival   = req_ch.arrive_at;
                     wr_rec.remaining = req_ch.burst_length;
                     wr_rec.prio      = req_ch.initial_priority;
                     wr_rec.wait_mark = '0;
                     valid_in[wr_addr]   = 1'b1;
                     queued_in[wr_addr]  = 1'b0;
                     started_in[wr_addr] = 1'b0;
                  end
               end else begin
                  // slot 0 is being read now; scan starts next cycle
                  idx_in        = '0;
                  best_found_in = 1'b0;
                  pend_in       = '0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            wr_en            = 1'b1;
            wr_rec.prio      = s_prio2;
            wr_rec.wait_mark = s_age ? now_ff : s_mark1;
            queued_in[idx_ff] = s_q1;
            if (s_valid && (rd_rec_ff.remaining != '0)) begin
               pend_in = count_type'(pend_ff + 1'b1);
            end
            if (s_better) begin
               best_found_in = 1'b1;
               best_idx_in   = idx_ff;
               best_rec_in   = wr_rec;
            end
            rd_addr = s_last ? '0 : slot_idx_type'(idx_ff + 1'b1);
            idx_in  = rd_addr;
            if (s_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rsp_in.tick_time       = now_ff;
               now_in                 = now_next;
               if (best_found_ff) begin
                  wr_en            = 1'b1;
                  wr_addr          = best_idx_ff;
                  wr_rec           = best_rec_ff;
                  wr_rec.remaining = new_rem;
                  wr_rec.wait_mark = now_next;
                  started_in[best_idx_ff] = 1'b1;
                  if (fin) begin
                     queued_in[best_idx_ff] = 1'b0;
                  end
                  if (sw) begin
                     sw_total_in = sat_inc(sw_total_ff);
                  end
                  prev_id_in   = best_rec_ff.ident;
                  prev_busy_in = 1'b1;
                  rsp_in.running_slot    = slot_field_type'(best_idx_ff);
                  rsp_in.running_id      = best_rec_ff.ident;
                  rsp_in.context_switch  = sw;
                  rsp_in.first_run       = !started_ff[best_idx_ff];
                  rsp_in.finished        = fin;
                  rsp_in.finish_tick     = fin ? now_next : '0;
                  rsp_in.all_done        = (count_type'(pend_ff - fin) == '0);
                  rsp_in.switch_count    = sw ? sat_inc(sw_total_ff) : sw_total_ff;
               end else begin
                  prev_busy_in        = 1'b0;
                  rsp_in.idle         = 1'b1;
                  rsp_in.all_done     = (pend_ff == '0);
                  rsp_in.switch_count = sw_total_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_rec;
      end
      rd_rec_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         valid_ff      <= '0;
         queued_ff     <= '0;
         started_ff    <= '0;
         best_found_ff <= 1'b0;
         pend_ff       <= '0;
         now_ff        <= '0;
         prev_id_ff    <= '0;
         prev_busy_ff  <= 1'b0;
         sw_total_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         queued_ff     <= queued_in;
         started_ff    <= started_in;
         best_found_ff <= best_found_in;
         pend_ff       <= pend_in;
         now_ff        <= now_in;
         prev_id_ff    <= prev_id_in;
         prev_busy_ff  <= prev_busy_in;
         sw_total_ff   <= sw_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= RST_AGE_LIMIT;
         boost_ff <= RST_AGING_BOOST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_AGE_LIMIT:   thr_ff   <= time_type'(csr_ch.data);
            CSR_AGING_BOOST: boost_ff <= prio_type'(csr_ch.data);
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.tick_time       = rsp_ff.tick_time;
   assign rsp_ch.idle            = rsp_ff.idle;
   assign rsp_ch.running_slot    = rsp_ff.running_slot;
   assign rsp_ch.running_id      = rsp_ff.running_id;
   assign rsp_ch.context_switch  = rsp_ff.context_switch;
   assign rsp_ch.first_run       = rsp_ff.first_run;
   assign rsp_ch.finished        = rsp_ff.finished;
   assign rsp_ch.finish_tick     = rsp_ff.finish_tick;
   assign rsp_ch.all_done        = rsp_ff.all_done;
   assign rsp_ch.switch_count    = rsp_ff.switch_count;

endmodule

`default_nettype wire

// ===== rtl/psas_checker.sv =====
// Port-level checks for the scheduler, bound onto the top level.
// Depends on psas_pkg and priority_sjf_aging_scheduler_assert.svh.
`default_nettype none

`include "priority_sjf_aging_scheduler_assert.svh"

module psas_checker import psas_pkg::*; (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_opcode,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_idle,
   input wire [3:0] rsp_running_slot,
   input wire [7:0] rsp_running_id,
   input wire       rsp_context_switch,
   input wire       rsp_first_run,
   input wire       rsp_finished,
   input wire [15:0] rsp_tick_time,
   input wire [15:0] rsp_finish_tick
);

   logic idle_clean;
   logic finish_ok;

   // idle ticks report no task
   assign idle_clean = (rsp_running_slot == 4'd0) && (rsp_running_id == 8'd0) &&
                       !rsp_context_switch && !rsp_first_run && !rsp_finished;

   // completion time is the saturated tick time plus one, zero otherwise
   assign finish_ok = rsp_finished ?
      ((rsp_tick_time != 16'hFFFF && rsp_finish_tick == rsp_tick_time + 16'd1) ||
       (rsp_tick_time == 16'hFFFF && rsp_finish_tick == 16'hFFFF)) :
      (rsp_finish_tick == 16'd0);

   // a result is held until its transfer
   `PSAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // a tick occupies the scan engine, so the next cycle is never ready
   `PSAS_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && (req_opcode == OP_TICK), !req_ready)

   `PSAS_ASSERT_NOW(a_idle_clean, rsp_valid && rsp_idle, idle_clean)

   `PSAS_ASSERT_NOW(a_completion, rsp_valid, finish_ok)

endmodule

bind priority_sjf_aging_scheduler psas_checker u_psas_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_opcode          (req_ch.opcode),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_idle            (rsp_ch.idle),
   .rsp_running_slot    (rsp_ch.running_slot),
   .rsp_running_id      (rsp_ch.running_id),
   .rsp_context_switch  (rsp_ch.context_switch),
   .rsp_first_run       (rsp_ch.first_run),
   .rsp_finished        (rsp_ch.finished),
   .rsp_tick_time       (rsp_ch.tick_time),
   .rsp_finish_tick     (rsp_ch.finish_tick)
);

`default_nettype wire

// ===== bench/priority_sjf_aging_scheduler_test.sv =====
// Self-checking bench for priority_sjf_aging_scheduler: random load/tick traffic,
// with register changes between phases and results checked against a scheduler model.
// Depends on psas_pkg, the channel interfaces in psas_if.sv and the RTL top.

module priority_sjf_aging_scheduler_test import psas_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam csr_idx_type CSR_UNUSED_A = 2'd2;
   localparam csr_idx_type CSR_UNUSED_B = 2'd3;

   typedef struct packed {
      logic           opcode;
      slot_field_type slot;
      ident_type      task_id;
      time_type       arrive_at;
      time_type       burst_length;
      prio_type       initial_priority;
   } sched_item_type;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // Scheduler model: slot file, time, switch history and the ticks still owed.
   class sched_model_type;
      logic      loaded    [MaxTasks];
      ident_type ident     [MaxTasks];
      time_type  arrival   [MaxTasks];
      time_type  remaining [MaxTasks];
      prio_type  prio      [MaxTasks];
      time_type  wait_mark [MaxTasks];
      logic      queued    [MaxTasks];
      logic      started   [MaxTasks];
      time_type  now;
      time_type  switch_total;
      time_type  threshold;
      prio_type  boost;
      ident_type last_ident;
      logic      last_busy;
      rsp_payload_type expected_ticks[$];
      int        mismatches;

      function new();
         for (int i = 0; i < MaxTasks; i++) begin
            loaded[i]    = 1'b0;
            ident[i]     = '0;
            arrival[i]   = '0;
            remaining[i] = '0;
            prio[i]      = '0;
            wait_mark[i] = '0;
            queued[i]    = 1'b0;
            started[i]   = 1'b0;
         end
         now          = '0;
         switch_total = '0;
         last_ident   = '0;
         last_busy    = 1'b0;
         threshold    = RST_AGE_LIMIT;
         boost        = RST_AGING_BOOST;
         mismatches   = 0;
      endfunction

      function time_type bump(time_type v);
         return (v == TIME_MAX) ? v : time_type'(v + 16'd1);
      endfunction

      function void write_reg(csr_idx_type idx, logic [CsrDataW-1:0] data);
         case (idx)
            CSR_AGE_LIMIT:   threshold = data;
            CSR_AGING_BOOST: boost = data[3:0];
            default: ;
         endcase
      endfunction

      function void take_item(sched_item_type it);
         rsp_payload_type r;
         int       best;
         int       level;
         int       s;
         time_type waited;
         logic     sw;
         logic     done;
         if (it.opcode == OP_LOAD) begin
            s = it.slot;
            if (s < MaxTasks) begin
               loaded[s]    = 1'b1;
               ident[s]     = it.task_id;
               arrival[s]   = it.arrive_at;
               remaining[s] = it.burst_length;
               prio[s]      = it.initial_priority;
               wait_mark[s] = '0;
               queued[s]    = 1'b0;
               started[s]   = 1'b0;
            end
            return;
         end
         for (int i = 0; i < MaxTasks; i++) begin
            if (loaded[i] && !queued[i] && remaining[i] != 0 && arrival[i] <= now) begin
               queued[i]    = 1'b1;
               wait_mark[i] = now;
            end
         end
         for (int i = 0; i < MaxTasks; i++) begin
            if (loaded[i] && queued[i] && prio[i] > 1) begin
               waited = (now >= wait_mark[i]) ? time_type'(now - wait_mark[i]) : '0;
               if (waited >= threshold) begin
                  level        = prio[i];
                  prio[i]      = (level > int'(boost) + 1) ? prio_type'(level - boost) : 4'd1;
                  wait_mark[i] = now;
               end
            end
         end
         best = -1;
         for (int i = 0; i < MaxTasks; i++) begin
            if (!(loaded[i] && queued[i] && remaining[i] != 0)) continue;
            if (best < 0 || prio[i] < prio[best] ||
                (prio[i] == prio[best] && remaining[i] < remaining[best]))
               best = i;
         end
         r = '0;
         r.tick_time = now;
         if (best < 0) begin
            r.idle    = 1'b1;
            last_busy = 1'b0;
            now       = bump(now);
         end else begin
            sw = last_busy && (last_ident != ident[best]);
            if (sw) switch_total = bump(switch_total);
            last_ident         = ident[best];
            last_busy          = 1'b1;
            r.running_slot     = slot_field_type'(best);
            r.running_id       = ident[best];
            r.context_switch   = sw;
            r.first_run        = !started[best];
            started[best]      = 1'b1;
            remaining[best]    = time_type'(remaining[best] - 16'd1);
            now                = bump(now);
            wait_mark[best]    = now;
            if (remaining[best] == 0) begin
               r.finished    = 1'b1;
               r.finish_tick = now;
               queued[best]  = 1'b0;
            end
         end
         done = 1'b1;
         for (int i = 0; i < MaxTasks; i++)
            if (loaded[i] && remaining[i] != 0) done = 1'b0;
         r.all_done     = done;
         r.switch_count = switch_total;
         expected_ticks = {expected_ticks, r};
      endfunction

      function string show(rsp_payload_type r);
         return $sformatf({"t=%0d idle=%0b slot=%0d id=%0d sw=%0b first=%0b fin=%0b",
                           " done_at=%0d all_done=%0b switches=%0d"},
                          r.tick_time, r.idle, r.running_slot, r.running_id,
                          r.context_switch, r.first_run, r.finished, r.finish_tick,
                          r.all_done, r.switch_count);
      endfunction

      function void check_tick(rsp_payload_type got);
         rsp_payload_type want;
         logic bad;
         if (expected_ticks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", show(got));
            return;
         end
         want = expected_ticks.pop_front();
         bad = (got.tick_time !== want.tick_time) || (got.idle !== want.idle) ||
               (got.running_slot !== want.running_slot) ||
               (got.running_id !== want.running_id) ||
               (got.context_switch !== want.context_switch) ||
               (got.first_run !== want.first_run) || (got.finished !== want.finished) ||
               (got.finish_tick !== want.finish_tick) ||
               (got.all_done !== want.all_done) || (got.switch_count !== want.switch_count);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tick mismatch\n  expected %s\n  actual   %s", show(want), show(got));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   psas_req_if req_ch ();
   psas_rsp_if rsp_ch ();
   psas_csr_if csr_ch ();

   priority_sjf_aging_scheduler DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sched_model_type tracker;
   int results_seen = 0;
   int gen_now = 0;
   int burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Monitor: every transfer goes to the model at the rising edge.
   always @(posedge clock) begin : monitor
      sched_item_type  it;
      rsp_payload_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.opcode           = req_ch.opcode;
            it.slot             = req_ch.slot;
            it.task_id          = req_ch.task_id;
            it.arrive_at        = req_ch.arrive_at;
            it.burst_length     = req_ch.burst_length;
            it.initial_priority = req_ch.initial_priority;
            tracker.take_item(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.tick_time       = rsp_ch.tick_time;
            got.idle            = rsp_ch.idle;
            got.running_slot    = rsp_ch.running_slot;
            got.running_id      = rsp_ch.running_id;
            got.context_switch  = rsp_ch.context_switch;
            got.first_run       = rsp_ch.first_run;
            got.finished        = rsp_ch.finished;
            got.finish_tick     = rsp_ch.finish_tick;
            got.all_done        = rsp_ch.all_done;
            got.switch_count    = rsp_ch.switch_count;
            tracker.check_tick(got);
            results_seen++;
         end
         if (csr_ch.valid && csr_ch.ready) tracker.write_reg(csr_ch.index, csr_ch.data);
      end
   end

   // Result side: changing stall patterns plus one long hold-off to back the block up.
   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      logic        held;
      mode      = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= 150) begin
            held      = 1'b1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            case (mode)
               RX_OPEN:     rsp_ch.ready <= 1'b1;
               RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 9) < 3);
               RX_PERIODIC: rsp_ch.ready <= (mode_left % 5 == 0);
               default:     rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   task automatic send_req(sched_item_type it);
      @(negedge clock);
      req_ch.valid            <= 1'b1;
      req_ch.opcode           <= it.opcode;
      req_ch.slot             <= it.slot;
      req_ch.task_id          <= it.task_id;
      req_ch.arrive_at        <= it.arrive_at;
      req_ch.burst_length     <= it.burst_length;
      req_ch.initial_priority <= it.initial_priority;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (it.opcode == OP_TICK && gen_now < 65535) gen_now++;
   endtask

   task automatic rest_req(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Bursts of random length, usually separated by random gaps; some long gap-free stretches.
   task automatic paced_send(sched_item_type it);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         rest_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      burst_left--;
      send_req(it);
   endtask

   // Stop offering, let every owed tick arrive, then cover a load still in flight.
   task automatic drain();
      rest_req(1);
      while (tracker.expected_ticks.size() != 0) @(posedge clock);
      repeat (MaxTasks + 8) @(posedge clock);
   endtask

   task automatic program_reg(csr_idx_type idx, logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic sched_item_type noise_item();
      sched_item_type it;
      it.opcode           = $urandom_range(0, 1);
      it.slot             = slot_field_type'($urandom);
      it.task_id          = ident_type'($urandom);
      it.arrive_at        = time_type'($urandom);
      it.burst_length     = time_type'($urandom);
      it.initial_priority = prio_type'($urandom);
      return it;
   endfunction

   function automatic sched_item_type make_tick();
      sched_item_type it;
      it        = noise_item();
      it.opcode = OP_TICK;
      return it;
   endfunction

   function automatic sched_item_type load_item(int slot, int id, int arr, int burst, int pr);
      sched_item_type it;
      it.opcode           = OP_LOAD;
      it.slot             = slot_field_type'(slot);
      it.task_id          = ident_type'(id);
      it.arrive_at        = time_type'(arr);
      it.burst_length     = time_type'(burst);
      it.initial_priority = prio_type'(pr);
      return it;
   endfunction

   // Arrivals mostly near the current tick so tasks get admitted soon; bursts mostly short.
   function automatic sched_item_type make_load();
      sched_item_type it;
      int             pick;
      it        = noise_item();
      it.opcode = OP_LOAD;
      pick      = $urandom_range(0, 9);
      if (pick == 2)
         it.arrive_at = time_type'(gen_now - $urandom_range(0, (gen_now < 20) ? gen_now : 20));
      else if (pick > 2)
         it.arrive_at = time_type'((gen_now + 6 > 65535) ? 65535
                                   : gen_now + $urandom_range(0, 6));
      pick = $urandom_range(0, 99);
      if (pick < 80)      it.burst_length = time_type'($urandom_range(1, 6));
      else if (pick < 90) it.burst_length = time_type'($urandom_range(7, 40));
      else if (pick >= 97) it.burst_length = '0;
      return it;
   endfunction

   task automatic random_phase(int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 9) == 0) begin
            paced_send(noise_item());
            sent++;
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) paced_send(make_load());
            sent += n;
            n = $urandom_range(1, 25);
            repeat (n) paced_send(make_tick());
            sent += n;
         end
      end
   endtask

   initial begin
      tracker = new();
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.opcode           = OP_LOAD;
      req_ch.slot             = '0;
      req_ch.task_id          = '0;
      req_ch.arrive_at        = '0;
      req_ch.burst_length     = '0;
      req_ch.initial_priority = '0;
      csr_ch.valid            = 1'b0;
      csr_ch.index            = CSR_AGE_LIMIT;
      csr_ch.data             = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty tick, field extremes, zero burst, overwrite, equal ids, late arrival.
      send_req(make_tick());
      send_req(load_item(0, 255, 0, 3, 15));
      send_req(load_item(15, 0, 0, 1, 0));
      send_req(load_item(7, 8'h5A, 65535, 65535, 1));
      send_req(load_item(3, 3, 0, 0, 0));
      send_req(load_item(5, 8'h11, 2, 2, 15));
      repeat (3) send_req(make_tick());
      send_req(load_item(0, 8'hA5, 0, 2, 15));
      send_req(load_item(9, 8'hA5, 0, 2, 15));
      repeat (6) send_req(make_tick());
      send_req(load_item(8, 255, 0, 1, 1));
      repeat (3) send_req(make_tick());
      send_req(load_item(7, 8'h3C, 0, 1, 0));
      repeat (3) send_req(make_tick());

      drain();
      program_reg(CSR_AGE_LIMIT, 16'd0);
      program_reg(CSR_AGING_BOOST, 16'd15);
      random_phase(370);

      drain();
      program_reg(CSR_AGE_LIMIT, 16'hFFFF);
      program_reg(CSR_AGING_BOOST, 16'd0);
      random_phase(360);

      drain();
      program_reg(CSR_AGE_LIMIT, 16'd3);
      program_reg(CSR_AGING_BOOST, 16'hFFF1);
      program_reg(CSR_UNUSED_A, CsrDataW'($urandom));
      program_reg(CSR_UNUSED_B, CsrDataW'($urandom));
      random_phase(360);

      drain();
      program_reg(CSR_AGE_LIMIT, CsrDataW'($urandom_range(1, 10)));
      program_reg(CSR_AGING_BOOST, CsrDataW'($urandom));
      random_phase(360);

      drain();
      program_reg(CSR_AGE_LIMIT, CsrDataW'($urandom));
      program_reg(CSR_AGING_BOOST, 16'd2);
      random_phase(360);

      drain();
      if (tracker.mismatches == 0 && tracker.expected_ticks.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psas_pkg.sv
rtl/psas_if.sv
rtl/priority_sjf_aging_scheduler.sv
rtl/psas_checker.sv
bench/priority_sjf_aging_scheduler_test.sv
